@@ rtl/sensor_hub_packet_parser_macros.svh @@
// Assertion macros shared by the sensor hub packet parser RTL.
// No dependencies; included by files that carry concurrent checks.
`ifndef SENSOR_HUB_PACKET_PARSER_MACROS_SVH
`define SENSOR_HUB_PACKET_PARSER_MACROS_SVH

`ifndef NO_ASSERTIONS
// property must hold at every clock edge outside reset
`define SHPP_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");
// expression must never be true outside reset
`define SHPP_ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define SHPP_ASSERT(lbl, clk, rst, prop)
`define SHPP_ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

@@ rtl/shpp_pkg.sv @@
// Types and constants for the sensor hub packet parser.
// No dependencies; imported by every parser module.
package shpp_pkg;

  // one input item
  typedef struct packed {
    logic       first_byte;
    logic [7:0] data_byte;
  } in_item_t;

  // one result item
  typedef struct packed {
    logic               result_kind;
    logic        [1:0]  accuracy;
    logic signed [15:0] quat_i;
    logic signed [15:0] quat_j;
    logic signed [15:0] quat_k;
    logic signed [15:0] quat_real;
  } result_t;

  // result kinds
  localparam logic KIND_ROTATION = 1'b0;
  localparam logic KIND_LEN_ERR  = 1'b1;

  // report kinds being walked
  localparam logic [1:0] RPT_NONE = 2'd0;
  localparam logic [1:0] RPT_ROT  = 2'd1;
  localparam logic [1:0] RPT_TIME = 2'd2;

  // header byte positions
  localparam int HDR_LEN_LO  = 0;
  localparam int HDR_LEN_HI  = 1;
  localparam int HDR_CHANNEL = 2;
  localparam int HDR_SEQ     = 3;

  localparam logic [7:0] ID_ROTATION = 8'h08;
  localparam logic [7:0] ID_TIME     = 8'hFB;
  localparam logic [7:0] CHAN_GAME   = 8'h03;
  localparam logic [7:0] CHAN_WAKE   = 8'h04;

  localparam int LEN_W       = 15;  // header length bits kept
  localparam int CMP_W       = 16;  // width for length compares
  localparam int MIN_BAD_LEN = 4;   // lengths up to this are invalid
  localparam int ROT_LEN     = 14;

  // offsets inside a report
  localparam logic [3:0] OFF_ACCURACY  = 4'd2;
  localparam logic [3:0] OFF_QUAT_LO   = 4'd4;
  localparam logic [3:0] OFF_QUAT_HI   = 4'd11;
  localparam logic [3:0] OFF_ROT_LAST  = 4'd13;
  localparam logic [3:0] OFF_TIME_LAST = 4'd4;

endpackage

@@ rtl/sensor_hub_packet_parser.sv @@
// Throughput: one byte per cycle unless m_tready stalls the full result register;
// header and report decoding is one shallow combinational step between the input
// register and the result register; a result reaches m_* through both registers.
// Reset (rst, synchronous, active high): parser idle until a byte flagged as
// first arrives; both register stages empty.
// Depends on shpp_pkg, shpp_in_reg, shpp_decode, shpp_out_reg.
module sensor_hub_packet_parser #(
  parameter int MAX_PACKET_BYTES = 256   // largest valid header length, 8..32767
) (
  input  logic        clk,
  input  logic        rst,
  // input bytes
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] first_byte
  // results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // [1:0] accuracy, [17:2] quat_i, [33:18] quat_j,
                                 // [49:34] quat_k, [65:50] quat_real, [71:66] zero
  output logic        m_tuser    // [0] result_kind
);
  import shpp_pkg::*;

  in_item_t s_item;
  in_item_t held_item;
  logic     held_valid;
  logic     advance;
  logic     step;
  logic     res_valid;
  result_t  res;
  result_t  m_res;

  assign s_item.data_byte  = s_tdata;
  assign s_item.first_byte = s_tuser;

  // input register: takes a new item whenever it is empty or the held one moves on
  shpp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_valid    (s_tvalid),
    .s_ready    (s_tready),
    .s_item     (s_item),
    .advance    (advance),
    .held_valid (held_valid),
    .held_item  (held_item)
  );

  // the held item is decoded whenever the result register has room
  assign step = held_valid && advance;

  shpp_decode #(
    .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
  ) u_decode (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (held_item),
    .res_valid (res_valid),
    .res       (res)
  );

  // result register: parts the output handshake from the decoder
  shpp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .m_valid   (m_tvalid),
    .m_ready   (m_tready),
    .m_res     (m_res)
  );

  assign m_tuser = m_res.result_kind;
  assign m_tdata = {6'd0, m_res.quat_real, m_res.quat_k, m_res.quat_j,
                    m_res.quat_i, m_res.accuracy};

endmodule

@@ rtl/shpp_in_reg.sv @@
// Input register stage of the sensor hub packet parser.
// Depends on shpp_pkg.
module shpp_in_reg (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_valid,
  output logic                s_ready,
  input  shpp_pkg::in_item_t  s_item,
  input  logic                advance,   // downstream takes the held item
  output logic                held_valid,
  output shpp_pkg::in_item_t  held_item
);
  import shpp_pkg::*;

  assign s_ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (s_ready) begin
      held_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_valid && s_ready) begin
      held_item <= s_item;
    end
  end

endmodule

@@ rtl/shpp_decode.sv @@
// Per-byte header and report decoder of the sensor hub packet parser.
// Depends on shpp_pkg and sensor_hub_packet_parser_macros.svh.
`include "sensor_hub_packet_parser_macros.svh"

module shpp_decode #(
  parameter int MAX_PACKET_BYTES = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               step,        // consume item this cycle
  input  shpp_pkg::in_item_t item,
  output logic               res_valid,
  output shpp_pkg::result_t  res
);
  import shpp_pkg::*;

  localparam int IDX_W = $clog2(MAX_PACKET_BYTES + 1);

  logic [IDX_W-1:0]  byte_index, byte_index_next;
  logic [LEN_W-1:0]  packet_len, packet_len_next;
  logic [3:0]        report_offset, report_offset_next;
  logic [1:0]        report_type, report_type_next;
  logic              parse_stopped, parse_stopped_next;
  logic [1:0]        cap_accuracy, cap_accuracy_next;
  logic [3:0][15:0]  cap_quat, cap_quat_next;

  always_comb begin
    logic [IDX_W-1:0] cur_idx;
    logic [3:0]       cur_off;
    logic [1:0]       cur_typ;
    logic             cur_stop;
    logic             do_stop;
    logic [7:0]       b;
    logic [LEN_W-1:0] new_len;
    logic [3:0]       off_rel;
    logic [1:0]       qi;

    b        = item.data_byte;
    cur_idx  = item.first_byte ? '0 : byte_index;
    cur_off  = item.first_byte ? 4'd0 : report_offset;
    cur_typ  = item.first_byte ? RPT_NONE : report_type;
    cur_stop = item.first_byte ? 1'b0 : parse_stopped;
    do_stop  = 1'b0;
    new_len  = {b[LEN_W-9:0], packet_len[7:0]};
    off_rel  = cur_off - OFF_QUAT_LO;
    qi       = off_rel[2:1];

    byte_index_next    = cur_idx;
    packet_len_next    = packet_len;
    report_offset_next = cur_off;
    report_type_next   = cur_typ;
    parse_stopped_next = cur_stop;
    cap_accuracy_next  = cap_accuracy;
    cap_quat_next      = cap_quat;
    res_valid          = 1'b0;
    res                = '0;

    if (!cur_stop) begin
      if (cur_idx == IDX_W'(HDR_LEN_LO)) begin
        packet_len_next = LEN_W'(b);
        byte_index_next = IDX_W'(HDR_LEN_HI);
      end else if (cur_idx == IDX_W'(HDR_LEN_HI)) begin
        packet_len_next = new_len;
        byte_index_next = IDX_W'(HDR_CHANNEL);
        if (CMP_W'(new_len) <= CMP_W'(MIN_BAD_LEN) ||
            CMP_W'(new_len) > CMP_W'(MAX_PACKET_BYTES)) begin
          do_stop         = 1'b1;
          res_valid       = 1'b1;
          res.result_kind = KIND_LEN_ERR;
        end
      end else if (cur_idx == IDX_W'(HDR_CHANNEL)) begin
        byte_index_next = IDX_W'(HDR_SEQ);
        if (b != CHAN_GAME && b != CHAN_WAKE) begin
          do_stop = 1'b1;
        end
      end else if (cur_idx == IDX_W'(HDR_SEQ)) begin
        byte_index_next = IDX_W'(HDR_SEQ + 1);
        if (CMP_W'(HDR_SEQ + 1) >= CMP_W'(packet_len)) begin
          do_stop = 1'b1;
        end
      end else begin
        // payload byte
        byte_index_next = cur_idx + 1'b1;
        if (cur_off == 4'd0) begin
          if (b == ID_ROTATION) begin
            if (CMP_W'(cur_idx) + CMP_W'(ROT_LEN) > CMP_W'(packet_len)) begin
              do_stop = 1'b1;   // report would overrun the packet
            end else begin
              report_type_next   = RPT_ROT;
              report_offset_next = 4'd1;
            end
          end else if (b == ID_TIME) begin
            report_type_next   = RPT_TIME;
            report_offset_next = 4'd1;
          end else begin
            do_stop = 1'b1;
          end
        end else if (cur_typ == RPT_ROT) begin
          if (cur_off == OFF_ACCURACY) begin
            cap_accuracy_next = b[1:0];
          end else if (cur_off >= OFF_QUAT_LO && cur_off <= OFF_QUAT_HI) begin
            if (!cur_off[0]) begin
              cap_quat_next[qi][7:0] = b;
            end else begin
              cap_quat_next[qi][15:8] = b;
            end
          end
          if (cur_off >= OFF_ROT_LAST) begin
            res_valid          = 1'b1;
            res.result_kind    = KIND_ROTATION;
            res.accuracy       = cap_accuracy_next;
            res.quat_i         = cap_quat_next[0];
            res.quat_j         = cap_quat_next[1];
            res.quat_k         = cap_quat_next[2];
            res.quat_real      = cap_quat_next[3];
            report_offset_next = 4'd0;
            report_type_next   = RPT_NONE;
          end else begin
            report_offset_next = cur_off + 4'd1;
          end
        end else begin
          // time report: skip its bytes
          if (cur_off >= OFF_TIME_LAST) begin
            report_offset_next = 4'd0;
            report_type_next   = RPT_NONE;
          end else begin
            report_offset_next = cur_off + 4'd1;
          end
        end
        if (CMP_W'(cur_idx) + CMP_W'(1) >= CMP_W'(packet_len)) begin
          do_stop = 1'b1;
        end
      end
    end

    if (do_stop) begin
      parse_stopped_next = 1'b1;
      report_offset_next = 4'd0;
      report_type_next   = RPT_NONE;
    end

    res_valid = res_valid && step;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      packet_len    <= '0;
      report_offset <= 4'd0;
      report_type   <= RPT_NONE;
      parse_stopped <= 1'b1;
    end else if (step) begin
      byte_index    <= byte_index_next;
      packet_len    <= packet_len_next;
      report_offset <= report_offset_next;
      report_type   <= report_type_next;
      parse_stopped <= parse_stopped_next;
    end
  end

  // every capture byte is rewritten before a rotation result, no reset needed
  always_ff @(posedge clk) begin
    if (step) begin
      cap_accuracy <= cap_accuracy_next;
      cap_quat     <= cap_quat_next;
    end
  end

  `SHPP_ASSERT(a_idle_after_reset, clk, rst, $past(rst) |-> parse_stopped)
  `SHPP_ASSERT_NEVER(a_offset_without_report, clk, rst,
                     report_offset != 4'd0 && report_type == RPT_NONE)
  `SHPP_ASSERT_NEVER(a_offset_range, clk, rst,
                     (report_type == RPT_ROT && report_offset > OFF_ROT_LAST) ||
                     (report_type == RPT_TIME && report_offset > OFF_TIME_LAST))
  `SHPP_ASSERT(a_err_result_clean, clk, rst,
               (res_valid && res.result_kind == KIND_LEN_ERR) |->
               (res.accuracy == 2'd0 && res.quat_i == 16'sd0 &&
                res.quat_j == 16'sd0 && res.quat_k == 16'sd0 &&
                res.quat_real == 16'sd0))

endmodule

@@ rtl/shpp_out_reg.sv @@
// Result register stage of the sensor hub packet parser.
// Depends on shpp_pkg.
module shpp_out_reg (
  input  logic               clk,
  input  logic               rst,
  input  logic               res_valid,
  input  shpp_pkg::result_t  res,
  output logic               advance,   // room for the next result
  output logic               m_valid,
  input  logic               m_ready,
  output shpp_pkg::result_t  m_res
);
  import shpp_pkg::*;

  assign advance = !m_valid || m_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_valid <= 1'b0;
    end else if (advance) begin
      m_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_res <= res;
    end
  end

endmodule
